FILE: hw/rtl/sapc_pkg.sv
// Shared types and constants of the source address packet counter.
package sapc_pkg;

	localparam int ETHER_W = 16;
	localparam int PROTO_W = 8;
	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 32;
	localparam int INDEX_W = 6;
	localparam int OUTCOME_W = 2;

	localparam logic [ETHER_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 32'hFFFF_FFFF;

	localparam logic [OUTCOME_W-1:0] OUTCOME_IGNORED     = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_INCREMENTED = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_ADDED       = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUTCOME_FULL        = 2'd3;

	// One classified item on its way from the front end to the back end
	typedef struct packed {
		logic              counted;
		logic [ADDR_W-1:0] addr;
	} sapc_job_t;

endpackage

FILE: hw/rtl/sapc_if.sv
// Valid/ready channel interfaces for packet summaries and counter results.
interface sapc_in_if;
	import sapc_pkg::*;
	logic               valid;
	logic               ready;
	logic [ETHER_W-1:0] ether_type;
	logic [PROTO_W-1:0] ip_protocol;
	logic [ADDR_W-1:0]  source_address;

	modport source(output valid, ether_type, ip_protocol, source_address, input ready);
	modport sink(input valid, ether_type, ip_protocol, source_address, output ready);
endinterface

interface sapc_out_if;
	import sapc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OUTCOME_W-1:0] outcome;
	logic [INDEX_W-1:0]   entry_index;
	logic [COUNT_W-1:0]   packet_count;

	modport source(output valid, outcome, entry_index, packet_count, input ready);
	modport sink(input valid, outcome, entry_index, packet_count, output ready);
endinterface

FILE: hw/rtl/sapc_front.sv
// Front end: classify incoming packet summaries and queue them for the back end.
module sapc_front (
	input  logic                clk,
	input  logic                arst_n,
	sapc_in_if.sink             pkt,
	output logic                job_valid,
	output sapc_pkg::sapc_job_t job,
	input  logic                job_ready
);
	import sapc_pkg::*;

	sapc_job_t  q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	sapc_job_t  new_job;

	always_comb begin
		pkt.ready       = (fill_q != 2'd2);
		push            = pkt.valid && pkt.ready;
		job_valid       = (fill_q != 2'd0);
		pop             = job_valid && job_ready;
		job             = q_mem_q[rd_ptr_q];
		new_job.counted = (pkt.ether_type == ETHERTYPE_IPV4) && (pkt.ip_protocol == PROTO_TCP);
		new_job.addr    = pkt.source_address;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/sapc_back.sv
// Back end: scan the address table, update or append the entry, register the result.
module sapc_back #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  sapc_pkg::sapc_job_t job,
	output logic                job_ready,
	sapc_out_if.source          res
);
	import sapc_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_CRD  = 2'd2;
	localparam logic [1:0] ST_CUPD = 2'd3;

	logic [ADDR_W-1:0]  addr_mem [TABLE_ENTRIES];
	logic [COUNT_W-1:0] cnt_mem  [TABLE_ENTRIES];

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   used_q;
	logic [CNT_W-1:0]   rd_ptr_q;
	logic               cmp_vld_q;
	logic [IDX_W-1:0]   cmp_idx_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [ADDR_W-1:0]  key_q;
	logic [ADDR_W-1:0]  addr_rd_q;
	logic [COUNT_W-1:0] cnt_rd_q;

	logic                 res_valid_q;
	logic [OUTCOME_W-1:0] res_outcome_q;
	logic [INDEX_W-1:0]   res_index_q;
	logic [COUNT_W-1:0]   res_count_q;

	logic               out_free;
	logic               match;
	logic               more;
	logic               table_full;
	logic               addr_re;
	logic               addr_we;
	logic               cnt_we;
	logic [IDX_W-1:0]   cnt_wr_idx;
	logic [COUNT_W-1:0] cnt_wr_data;
	logic [COUNT_W-1:0] cnt_inc;
	logic               emit;
	logic [OUTCOME_W-1:0] emit_outcome;
	logic [IDX_W-1:0]   emit_idx;
	logic [COUNT_W-1:0] emit_count;

	always_comb begin
		out_free   = !res_valid_q || res.ready;
		match      = cmp_vld_q && (addr_rd_q == key_q);
		more       = (rd_ptr_q < used_q);
		table_full = (used_q == CNT_W'(TABLE_ENTRIES));
		cnt_inc    = (cnt_rd_q == COUNT_MAX) ? COUNT_MAX : cnt_rd_q + COUNT_W'(1);

		job_ready    = 1'b0;
		addr_re      = 1'b0;
		addr_we      = 1'b0;
		cnt_we       = 1'b0;
		cnt_wr_idx   = hit_idx_q;
		cnt_wr_data  = cnt_inc;
		emit         = 1'b0;
		emit_outcome = OUTCOME_IGNORED;
		emit_idx     = '0;
		emit_count   = '0;

		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					if (job.counted) begin
						job_ready = 1'b1;
					end else if (out_free) begin
						job_ready = 1'b1;
						emit      = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (!match) begin
					if (more) begin
						addr_re = 1'b1;
					end else if (!cmp_vld_q && out_free) begin
						emit = 1'b1;
						if (table_full) begin
							emit_outcome = OUTCOME_FULL;
						end else begin
							// append the address with a first count of one
							addr_we      = 1'b1;
							cnt_we       = 1'b1;
							cnt_wr_idx   = used_q[IDX_W-1:0];
							cnt_wr_data  = COUNT_W'(1);
							emit_outcome = OUTCOME_ADDED;
							emit_idx     = used_q[IDX_W-1:0];
							emit_count   = COUNT_W'(1);
						end
					end
				end
			end
			ST_CUPD: begin
				if (out_free) begin
					cnt_we       = 1'b1;
					emit         = 1'b1;
					emit_outcome = OUTCOME_INCREMENTED;
					emit_idx     = hit_idx_q;
					emit_count   = cnt_inc;
				end
			end
			default: ;
		endcase
	end

	// Table storage: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (addr_we) begin
			addr_mem[used_q[IDX_W-1:0]] <= key_q;
		end
		if (addr_re) begin
			addr_rd_q <= addr_mem[rd_ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wr_idx] <= cnt_wr_data;
		end
		if (state_q == ST_CRD) begin
			cnt_rd_q <= cnt_mem[hit_idx_q];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid && job_ready) begin
			key_q <= job.addr;
		end
		if (addr_re) begin
			cmp_idx_q <= rd_ptr_q[IDX_W-1:0];
		end
		if (state_q == ST_SCAN && match) begin
			hit_idx_q <= cmp_idx_q;
		end
		if (emit) begin
			res_outcome_q <= emit_outcome;
			res_index_q   <= INDEX_W'(emit_idx);
			res_count_q   <= emit_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			rd_ptr_q    <= '0;
			cmp_vld_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (job_valid && job_ready && job.counted) begin
						rd_ptr_q  <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						state_q <= ST_CRD;
					end else if (more) begin
						rd_ptr_q  <= rd_ptr_q + CNT_W'(1);
						cmp_vld_q <= 1'b1;
					end else if (cmp_vld_q) begin
						// drain the last compare
						cmp_vld_q <= 1'b0;
					end else if (out_free) begin
						if (!table_full) begin
							used_q <= used_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_CRD: begin
					state_q <= ST_CUPD;
				end
				ST_CUPD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid        = res_valid_q;
	assign res.outcome      = res_outcome_q;
	assign res.entry_index  = res_index_q;
	assign res.packet_count = res_count_q;

endmodule

FILE: hw/rtl/source_address_packet_counter_top.sv
// Per-source-address packet counter: one result item for each packet summary item.
// Only IPv4 packets carrying TCP are counted; anything else comes back as ignored
// and leaves the table alone. A two-entry queue decouples the input from the table
// engine, which handles one item at a time. A counted item is found by a linear scan
// of the address table through its single read port, one slot per cycle. Counts
// saturate at all ones. entry_index carries the low six bits of the slot number.
// The tables need no clearing pass after reset.
module source_address_packet_counter_top #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	sapc_in_if.sink    pkt,
	sapc_out_if.source res
);
	import sapc_pkg::*;

	logic      job_valid;
	logic      job_ready;
	sapc_job_t job;

	sapc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready)
	);

	sapc_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.res       (res)
	);

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the source address packet counter against a table model.
`timescale 1ns / 100ps

module testbench;
	import sapc_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int ADDR_POOL     = 80;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 80;

	typedef struct packed {
		logic [ETHER_W-1:0] ether_type;
		logic [PROTO_W-1:0] ip_protocol;
		logic [ADDR_W-1:0]  source_address;
	} packet_summary_t;

	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic [INDEX_W-1:0]   entry_index;
		logic [COUNT_W-1:0]   packet_count;
	} counter_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic            pkt_valid = 1'b0;
	packet_summary_t offered = '0;
	logic            result_ready = 1'b0;

	sapc_in_if  pkt_if();
	sapc_out_if res_if();

	assign pkt_if.valid          = pkt_valid;
	assign pkt_if.ether_type     = offered.ether_type;
	assign pkt_if.ip_protocol    = offered.ip_protocol;
	assign pkt_if.source_address = offered.source_address;
	assign res_if.ready          = result_ready;

	source_address_packet_counter_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pkt   (pkt_if),
		.res   (res_if)
	);

	// Table model of the counter
	logic [ADDR_W-1:0]  known_addr [TABLE_ENTRIES];
	logic [COUNT_W-1:0] addr_count [TABLE_ENTRIES];
	int                 slots_used = 0;

	packet_summary_t packets_to_send[$];
	counter_result_t expected_results[$];
	logic [ADDR_W-1:0] addr_pool [ADDR_POOL];

	int packets_queued = 0;
	int packets_accepted = 0;
	int results_checked = 0;
	int outcome_seen [4] = '{0, 0, 0, 0};
	int errors = 0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic counter_result_t count_packet(packet_summary_t p);
		counter_result_t r = '0;
		int slot;
		r.outcome = OUTCOME_IGNORED;
		if (p.ether_type != ETHERTYPE_IPV4 || p.ip_protocol != PROTO_TCP)
			return r;
		for (slot = 0; slot < slots_used; slot++) begin
			if (known_addr[slot] == p.source_address) begin
				if (addr_count[slot] != COUNT_MAX)
					addr_count[slot] = addr_count[slot] + 1'b1;
				r.outcome      = OUTCOME_INCREMENTED;
				r.entry_index  = INDEX_W'(slot);
				r.packet_count = addr_count[slot];
				return r;
			end
		end
		if (slots_used < TABLE_ENTRIES) begin
			known_addr[slots_used] = p.source_address;
			addr_count[slots_used] = 1;
			r.outcome      = OUTCOME_ADDED;
			r.entry_index  = INDEX_W'(slots_used);
			r.packet_count = 1;
			slots_used++;
		end else begin
			r.outcome = OUTCOME_FULL;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic push_packet(logic [ETHER_W-1:0] et, logic [PROTO_W-1:0] pr,
			logic [ADDR_W-1:0] a);
		packets_to_send.push_back('{ether_type: et, ip_protocol: pr, source_address: a});
		packets_queued++;
	endtask

	task automatic queue_directed();
		// frames that must be ignored, fields at their extremes
		push_packet(16'h0000, PROTO_TCP, 32'h0000_0000);
		push_packet(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
		push_packet(ETHERTYPE_IPV4, 8'h00, 32'h0102_0304);
		push_packet(ETHERTYPE_IPV4, 8'hFF, 32'h0102_0304);
		push_packet(16'h86DD, PROTO_TCP, 32'h0102_0304);
		push_packet(16'h0801, PROTO_TCP, 32'h0000_0000);
		push_packet(ETHERTYPE_IPV4, 8'h07, 32'h0000_0000);
		// new entries, then repeats of them
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'h0000_0000);
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'hFFFF_FFFF);
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'h0000_0000);
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'hFFFF_FFFF);
		push_packet(16'h0000, 8'h00, 32'h0000_0000);
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'h0000_0000);
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'h8000_0000);
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'h0000_0001);
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'h8000_0000);
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'h7FFF_FFFF);
		push_packet(ETHERTYPE_IPV4, PROTO_TCP, 32'h0000_0001);
	endtask

	// Mostly counted packets from a pool a little larger than the table, so that
	// the table fills and later newcomers are dropped; the rest is noise.
	task automatic queue_random_packets(int target);
		int counted;
		int pick;
		logic [ETHER_W-1:0] et;
		logic [PROTO_W-1:0] pr;
		logic [ADDR_W-1:0]  a;
		counted = 0;
		while (counted < target) begin
			pick = $urandom_range(99);
			a  = addr_pool[$urandom_range(ADDR_POOL-1)];
			et = ETHERTYPE_IPV4;
			pr = PROTO_TCP;
			if (pick < 6) begin
				et = ETHER_W'($urandom);
			end else if (pick < 12) begin
				pr = PROTO_W'($urandom);
			end else if (pick < 18) begin
				et = ETHER_W'($urandom);
				pr = PROTO_W'($urandom);
				a  = $urandom;
			end else if (pick < 26) begin
				a = $urandom;
			end
			push_packet(et, pr, a);
			if (et == ETHERTYPE_IPV4 && pr == PROTO_TCP)
				counted++;
		end
	endtask

	task automatic run_phase(int idle, int stall, int target, bit long_hold);
		@(posedge clk);
		send_idle_pct <= idle;
		stall_pct <= stall;
		if (long_hold)
			hold_asked <= hold_asked + 1;
		queue_random_packets(target);
		// hold off the next phase until every result is back
		while (packets_accepted != packets_queued || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	// Driver: present one item at a time, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid <= 1'b0;
			offered <= '0;
		end else begin
			if (pkt_if.valid && pkt_if.ready) begin
				expected_results.push_back(count_packet(offered));
				packets_accepted++;
			end
			if (!pkt_if.valid || pkt_if.ready) begin
				if (packets_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered <= packets_to_send.pop_front();
					pkt_valid <= 1'b1;
				end else begin
					pkt_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result item and drive ready, with stalls and long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_given <= 0;
			hold_left <= 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: outcome %0d, index %0d, count 0x%0h",
						$time, res_if.outcome, res_if.entry_index, res_if.packet_count);
					errors++;
				end else begin
					counter_result_t want;
					want = expected_results.pop_front();
					check_field("outcome", 32'(want.outcome), 32'(res_if.outcome));
					check_field("entry_index", 32'(want.entry_index), 32'(res_if.entry_index));
					check_field("packet_count", want.packet_count, res_if.packet_count);
					outcome_seen[want.outcome]++;
					results_checked++;
				end
			end
			if (hold_given != hold_asked) begin
				hold_given <= hold_asked;
				hold_left <= HOLD_CYCLES;
				result_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL source_address_packet_counter_top");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < ADDR_POOL; i++)
			addr_pool[i] = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_directed();
		run_phase(0, 0, 250, 1'b0);
		run_phase(61, 0, 250, 1'b0);
		run_phase(0, 61, 250, 1'b0);
		run_phase(17, 17, 250, 1'b0);
		// sender keeps offering while the receiver holds off
		run_phase(0, 0, 270, 1'b1);

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d packet summaries, checked %0d results, %0d table slots in use.",
			packets_accepted, results_checked, slots_used);
		$display("Outcomes: %0d ignored, %0d incremented, %0d added, %0d dropped; %0d errors.",
			outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3], errors);
		if (errors == 0) begin
			$display("PASS source_address_packet_counter_top");
		end else begin
			$display("FAIL source_address_packet_counter_top");
		end
		$finish;
	end

endmodule
